### src/gee_pkg.sv
`timescale 1ns / 1ps
package gee_pkg;

  localparam int unsigned ELEM_W  = 32;
  localparam int unsigned OUT_IDX_W = 3;
  localparam int unsigned OUT_TDATA_W = 40;
  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W = 4;

  localparam logic [CFG_INDEX_W-1:0] CFG_ROWS_IN_USE = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_COLS_IN_USE = 2'd1;

  typedef enum logic [3:0] {
    S_LOAD,
    S_TOP,
    S_SR_RD,
    S_SR_CMP,
    S_SR_END,
    S_ROW,
    S_DIVST,
    S_DIVW,
    S_COL,
    S_RDT,
    S_MUL,
    S_RND,
    S_WR,
    S_OUT_RD,
    S_OUT_LD
  } state_t;

  typedef struct packed {
    logic perm_init;
    logic perm_swap;
    logic srch_clr;
    logic srch_cmp;
    logic div_start;
    logic rd;
    logic wr;
    logic wr_load;
    logic wr_zero;
    logic opa_ld;
    logic mul_ld;
    logic rnd_ld;
    logic out_ld;
    logic out_last;
  } cmd_t;

  typedef struct packed {
    logic best_zero;
    logic div_done;
    logic out_valid;
  } status_t;

endpackage

### src/gee_ram.sv
`timescale 1ns / 1ps
module gee_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### src/gee_div.sv
`timescale 1ns / 1ps
// rounded, saturating q16-style quotient, one quotient bit per cycle
module gee_div #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] num,
  input  logic [31:0] den,
  output logic        done,
  output logic [31:0] quot
);

  localparam int unsigned NW = FRAC_BITS + 35;
  localparam int unsigned CNT_W = $clog2(NW + 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [NW-1:0]    nq;
  logic [33:0]      rem;
  logic [33:0]      dd;
  logic             neg;
  logic [32:0]      num_mag;
  logic [32:0]      den_mag;
  logic [33:0]      rem_sh;
  logic             ge;

  assign num_mag = num[31] ? 33'(-{num[31], num}) : {1'b0, num};
  assign den_mag = den[31] ? 33'(-{den[31], den}) : {1'b0, den};
  assign rem_sh  = {rem[32:0], nq[NW-1]};
  assign ge      = (rem_sh >= dd);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(NW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      nq  <= (NW'(num_mag) << (FRAC_BITS + 1)) + NW'(den_mag);
      dd  <= {den_mag, 1'b0};
      rem <= '0;
      neg <= num[31] ^ den[31];
    end else if (busy) begin
      rem <= ge ? rem_sh - dd : rem_sh;
      nq  <= {nq[NW-2:0], ge};
    end
  end

  always_comb begin
    if (neg) begin
      if ((|nq[NW-1:32]) || (nq[31] && (|nq[30:0]))) begin
        quot = 32'h8000_0000;
      end else begin
        quot = -nq[31:0];
      end
    end else begin
      if (|nq[NW-1:31]) begin
        quot = 32'h7FFF_FFFF;
      end else begin
        quot = nq[31:0];
      end
    end
  end

endmodule

### src/gee_dp.sv
`timescale 1ns / 1ps
module gee_dp import gee_pkg::*; #(
  parameter int unsigned MAX_ROWS  = 8,
  parameter int unsigned MAX_COLS  = 8,
  parameter int unsigned FRAC_BITS = 16,
  parameter int unsigned RW  = 3,
  parameter int unsigned CW  = 3,
  parameter int unsigned CCW = 4,
  parameter int unsigned LCW = 7
) (
  input  logic              clk,
  input  logic              rst,
  input  cmd_t              cmd,
  input  logic [RW-1:0]     row,
  input  logic [CW-1:0]     col,
  input  logic [CCW-1:0]    nc,
  input  logic [LCW-1:0]    load_addr,
  input  logic [ELEM_W-1:0] in_data,
  input  logic              out_ready,
  output status_t           status,
  output logic [ELEM_W-1:0] out_value,
  output logic [OUT_IDX_W-1:0] out_row,
  output logic [OUT_IDX_W-1:0] out_col,
  output logic              out_last
);

  localparam int unsigned DEPTH = MAX_ROWS * MAX_COLS;
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned RAM_DEPTH = 1 << AW;
  localparam logic [63:0] HALF = 64'((64'd1 << FRAC_BITS) >> 1);

  logic [RW-1:0]     perm [MAX_ROWS];
  logic [RW-1:0]     phys_row;
  logic [AW-1:0]     addr;
  logic [ELEM_W-1:0] rdata;
  logic [ELEM_W-1:0] wdata;
  logic [32:0]       best;
  logic [32:0]       rmag;
  logic [RW-1:0]     piv;
  logic [RW-1:0]     piv_phys;
  logic [ELEM_W-1:0] pivot_val;
  logic [ELEM_W-1:0] coeff;
  logic [ELEM_W-1:0] quot;
  logic              div_done;
  logic [ELEM_W-1:0] opa;
  logic [ELEM_W-1:0] tgt;
  logic signed [63:0] prod;
  logic [63:0]       pmag;
  logic [63:0]       rmg;
  logic [ELEM_W-1:0] mres;
  logic [ELEM_W-1:0] mres_next;
  logic [32:0]       diff;
  logic [ELEM_W-1:0] diff_sat;
  logic              out_valid;

  assign phys_row = perm[row];
  assign addr = cmd.wr_load ? AW'(load_addr)
                            : AW'(32'(phys_row) * 32'(nc) + 32'(col));
  assign rmag = rdata[31] ? 33'(-{rdata[31], rdata}) : {1'b0, rdata};

  // saturating difference for the row update
  assign diff = {tgt[31], tgt} - {mres[31], mres};
  always_comb begin
    if (diff[32] != diff[31]) begin
      diff_sat = diff[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else begin
      diff_sat = diff[31:0];
    end
  end

  always_comb begin
    if (cmd.wr_load) begin
      wdata = in_data;
    end else if (cmd.wr_zero) begin
      wdata = '0;
    end else begin
      wdata = diff_sat;
    end
  end

  // product rounding, ties away from zero
  assign pmag = prod[63] ? 64'(-prod) : 64'(prod);
  assign rmg  = (pmag + HALF) >> FRAC_BITS;
  always_comb begin
    if (prod[63]) begin
      mres_next = (rmg > 64'h8000_0000) ? 32'h8000_0000 : -rmg[31:0];
    end else begin
      mres_next = (rmg > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : rmg[31:0];
    end
  end

  gee_ram #(
    .WIDTH(ELEM_W),
    .DEPTH(RAM_DEPTH)
  ) u_store (
    .clk    (clk),
    .wr_en  (cmd.wr),
    .wr_addr(addr),
    .wr_data(wdata),
    .rd_en  (cmd.rd),
    .rd_addr(addr),
    .rd_data(rdata)
  );

  gee_div #(
    .FRAC_BITS(FRAC_BITS)
  ) u_div (
    .clk  (clk),
    .rst  (rst),
    .start(cmd.div_start),
    .num  (rdata),
    .den  (pivot_val),
    .done (div_done),
    .quot (quot)
  );

  // row permutation replaces physical row swaps
  always_ff @(posedge clk) begin
    if (cmd.perm_init) begin
      for (int r = 0; r < MAX_ROWS; r++) begin
        perm[r] <= RW'(r);
      end
    end else if (cmd.perm_swap) begin
      perm[row] <= piv_phys;
      perm[piv] <= phys_row;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.srch_clr) begin
      best <= '0;
    end else if (cmd.srch_cmp && (rmag > best)) begin
      best      <= rmag;
      piv       <= row;
      piv_phys  <= phys_row;
      pivot_val <= rdata;
    end
    if (div_done) begin
      coeff <= quot;
    end
    if (cmd.opa_ld) begin
      opa <= rdata;
    end
    if (cmd.mul_ld) begin
      tgt  <= rdata;
      prod <= $signed(opa) * $signed(coeff);
    end
    if (cmd.rnd_ld) begin
      mres <= mres_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_ld) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_ld) begin
      out_value <= rdata;
      out_row   <= OUT_IDX_W'(row);
      out_col   <= OUT_IDX_W'(col);
      out_last  <= cmd.out_last;
    end
  end

  assign status.best_zero = (best == '0);
  assign status.div_done  = div_done;
  assign status.out_valid = out_valid;

endmodule

### src/gee_ctrl.sv
`timescale 1ns / 1ps
module gee_ctrl import gee_pkg::*; #(
  parameter int unsigned RW  = 3,
  parameter int unsigned CW  = 3,
  parameter int unsigned RCW = 4,
  parameter int unsigned CCW = 4,
  parameter int unsigned LCW = 7
) (
  input  logic           clk,
  input  logic           rst,
  input  logic [RCW-1:0] nr,
  input  logic [CCW-1:0] nc,
  input  logic           in_fire,
  input  status_t        status,
  output cmd_t           cmd,
  output logic [RW-1:0]  row,
  output logic [CW-1:0]  col,
  output logic [LCW-1:0] load_addr,
  output logic           in_ready
);

  state_t         state;
  state_t         state_next;
  logic [RCW-1:0] h;
  logic [CCW-1:0] k;
  logic [RCW-1:0] i;
  logic [CCW-1:0] j;
  logic [LCW-1:0] load_count;
  logic           load_done;
  logic           elim_done;

  assign load_done = (32'(load_count) + 32'd1) >= (32'(nr) * 32'(nc));
  assign elim_done = (h >= nr) || (k >= nc);
  assign load_addr = load_count;
  assign in_ready  = (state == S_LOAD);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      load_count <= '0;
      h <= '0;
      k <= '0;
      i <= '0;
      j <= '0;
    end else begin
      case (state)
        S_LOAD: begin
          if (in_fire) begin
            if (load_done) begin
              load_count <= '0;
              h <= '0;
              k <= '0;
            end else begin
              load_count <= load_count + 1'b1;
            end
          end
        end
        S_TOP: begin
          if (elim_done) begin
            i <= '0;
            j <= '0;
          end else begin
            i <= h;
          end
        end
        S_SR_CMP: i <= i + 1'b1;
        S_SR_END: begin
          if (status.best_zero) begin
            k <= k + 1'b1;
          end else begin
            i <= h + 1'b1;
          end
        end
        S_ROW: begin
          if (i >= nr) begin
            h <= h + 1'b1;
            k <= k + 1'b1;
          end
        end
        S_DIVW: begin
          if (status.div_done) begin
            j <= k + 1'b1;
          end
        end
        S_COL: begin
          if (j >= nc) begin
            i <= i + 1'b1;
          end
        end
        S_WR: j <= j + 1'b1;
        S_OUT_LD: begin
          if ((32'(j) + 32'd1) >= 32'(nc)) begin
            j <= '0;
            i <= i + 1'b1;
          end else begin
            j <= j + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    row = RW'(i);
    col = CW'(j);
    case (state)
      S_LOAD: begin
        if (in_fire) begin
          cmd.wr      = 1'b1;
          cmd.wr_load = 1'b1;
          if (load_done) begin
            cmd.perm_init = 1'b1;
            state_next    = S_TOP;
          end
        end
      end
      S_TOP: begin
        if (elim_done) begin
          state_next = S_OUT_RD;
        end else begin
          cmd.srch_clr = 1'b1;
          state_next   = S_SR_RD;
        end
      end
      S_SR_RD: begin
        col        = CW'(k);
        cmd.rd     = 1'b1;
        state_next = S_SR_CMP;
      end
      S_SR_CMP: begin
        col          = CW'(k);
        cmd.srch_cmp = 1'b1;
        state_next   = ((32'(i) + 32'd1) < 32'(nr)) ? S_SR_RD : S_SR_END;
      end
      S_SR_END: begin
        row = RW'(h);
        if (status.best_zero) begin
          state_next = S_TOP;
        end else begin
          cmd.perm_swap = 1'b1;
          state_next    = S_ROW;
        end
      end
      S_ROW: begin
        col = CW'(k);
        if (i >= nr) begin
          state_next = S_TOP;
        end else begin
          cmd.rd     = 1'b1;
          state_next = S_DIVST;
        end
      end
      S_DIVST: begin
        cmd.div_start = 1'b1;
        state_next    = S_DIVW;
      end
      S_DIVW: begin
        col = CW'(k);
        if (status.div_done) begin
          cmd.wr      = 1'b1;
          cmd.wr_zero = 1'b1;
          state_next  = S_COL;
        end
      end
      S_COL: begin
        row = RW'(h);
        if (j >= nc) begin
          state_next = S_ROW;
        end else begin
          cmd.rd     = 1'b1;
          state_next = S_RDT;
        end
      end
      S_RDT: begin
        cmd.rd     = 1'b1;
        cmd.opa_ld = 1'b1;
        state_next = S_MUL;
      end
      S_MUL: begin
        cmd.mul_ld = 1'b1;
        state_next = S_RND;
      end
      S_RND: begin
        cmd.rnd_ld = 1'b1;
        state_next = S_WR;
      end
      S_WR: begin
        cmd.wr     = 1'b1;
        state_next = S_COL;
      end
      S_OUT_RD: begin
        cmd.rd = 1'b1;
        if (!status.out_valid) begin
          state_next = S_OUT_LD;
        end
      end
      S_OUT_LD: begin
        cmd.out_ld   = 1'b1;
        cmd.out_last = ((32'(i) + 32'd1) == 32'(nr)) && ((32'(j) + 32'd1) == 32'(nc));
        state_next   = cmd.out_last ? S_LOAD : S_OUT_RD;
      end
      default: state_next = S_LOAD;
    endcase
  end

  a_no_rd_wr: assert property (@(posedge clk) disable iff (rst) !(cmd.rd && cmd.wr))
    else $error("store read and write in one cycle");
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_ld |-> !status.out_valid)
    else $error("result register overwritten");
  a_last_to_load: assert property (@(posedge clk) disable iff (rst)
    (cmd.out_ld && cmd.out_last) |=> (state == S_LOAD))
    else $error("no return to loading after last result");
  a_div_wait: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |=> (state == S_DIVW))
    else $error("divider started outside its wait");

endmodule

### src/gaussian_elimination_echelon.sv
`timescale 1ns / 1ps
// Row echelon reduction of a signed Q16.16 matrix with partial pivoting. Elements load
// row-major one per cycle on the slave stream; the final element starts forward
// elimination, after which the matrix leaves row-major on the master stream with tlast on
// its final element. Timing is set by the single-port element store and the bit-serial
// divider: the pivot search reads each remaining row in turn, each eliminated row gets its
// coefficient from the divider and then updates each element through read, multiply, round
// and write steps, and emission reads each element and loads it into the result register
// once the previous result has been taken. Dimensions of 0 act as 1, values above the
// maximum act as the maximum; write them only while no run is in flight.
module gaussian_elimination_echelon import gee_pkg::*; #(
  parameter int unsigned MAX_ROWS  = 8,
  parameter int unsigned MAX_COLS  = 8,
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  // slave stream, tdata: element_value[31:0]
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [ELEM_W-1:0]      s_tdata,
  // master stream, tdata: result_value[31:0], result_row[34:32], result_col[37:35], zero pad
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata,
  output logic                   m_tlast,
  // configuration write channel
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int unsigned RW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int unsigned CW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int unsigned RCW = $clog2(MAX_ROWS + 1);
  localparam int unsigned CCW = $clog2(MAX_COLS + 1);
  localparam int unsigned LCW = $clog2(MAX_ROWS * MAX_COLS + 1);

  logic [CFG_DATA_W-1:0] rows_in_use;
  logic [CFG_DATA_W-1:0] cols_in_use;
  logic [RCW-1:0]        nr;
  logic [CCW-1:0]        nc;
  cmd_t                  cmd;
  status_t               status;
  logic [RW-1:0]         row;
  logic [CW-1:0]         col;
  logic [LCW-1:0]        load_addr;
  logic [ELEM_W-1:0]     out_value;
  logic [OUT_IDX_W-1:0]  out_row;
  logic [OUT_IDX_W-1:0]  out_col;

  // configuration transactions are always taken
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_in_use <= CFG_DATA_W'(8);
      cols_in_use <= CFG_DATA_W'(8);
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_ROWS_IN_USE: rows_in_use <= cfg_data;
        CFG_COLS_IN_USE: cols_in_use <= cfg_data;
        default: ;
      endcase
    end
  end

  // effective dimensions, clamped into 1..max
  always_comb begin
    if (rows_in_use == '0) begin
      nr = RCW'(1);
    end else if (32'(rows_in_use) > MAX_ROWS) begin
      nr = RCW'(MAX_ROWS);
    end else begin
      nr = RCW'(rows_in_use);
    end
    if (cols_in_use == '0) begin
      nc = CCW'(1);
    end else if (32'(cols_in_use) > MAX_COLS) begin
      nc = CCW'(MAX_COLS);
    end else begin
      nc = CCW'(cols_in_use);
    end
  end

  gee_ctrl #(
    .RW (RW),
    .CW (CW),
    .RCW(RCW),
    .CCW(CCW),
    .LCW(LCW)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .nr       (nr),
    .nc       (nc),
    .in_fire  (s_tvalid && s_tready),
    .status   (status),
    .cmd      (cmd),
    .row      (row),
    .col      (col),
    .load_addr(load_addr),
    .in_ready (s_tready)
  );

  gee_dp #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS),
    .FRAC_BITS(FRAC_BITS),
    .RW       (RW),
    .CW       (CW),
    .CCW      (CCW),
    .LCW      (LCW)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .row      (row),
    .col      (col),
    .nc       (nc),
    .load_addr(load_addr),
    .in_data  (s_tdata),
    .out_ready(m_tready),
    .status   (status),
    .out_value(out_value),
    .out_row  (out_row),
    .out_col  (out_col),
    .out_last (m_tlast)
  );

  // result register is held until its transaction completes
  assign m_tvalid = status.out_valid;
  assign m_tdata  = {2'b00, out_col, out_row, out_value};

endmodule

### bench/gaussian_elimination_echelon_tb.sv
`timescale 1ns / 1ps
module gaussian_elimination_echelon_tb;
  import gee_pkg::*;

  localparam int unsigned DIM_MAX = 8;
  localparam int unsigned FRAC = 16;
  localparam int unsigned STALL_LIMIT = 30000;
  localparam int unsigned HOLD_CYCLES = 4000;
  localparam int unsigned ITEM_TARGET = 270;
  // register indexes with no register behind them
  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_B = 2'd3;

  typedef struct packed {
    logic [31:0] value;
    logic [2:0]  row;
    logic [2:0]  col;
    logic        last;
  } echelon_elem_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [ELEM_W-1:0]      s_tdata = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   m_tlast;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  gaussian_elimination_echelon i_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  // elements waiting to be offered, and echelon results still owed by the block
  logic [31:0]   pending_elems[$];
  echelon_elem_t echelon_due[$];

  // predictor state: our own copy of registers and the loaded elements
  logic [3:0]  rows_reg = 4'd8;
  logic [3:0]  cols_reg = 4'd8;
  logic [31:0] elem_store[DIM_MAX*DIM_MAX];
  int unsigned elems_loaded = 0;

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned results_seen = 0;
  int unsigned items_sent = 0;
  bit          failed = 1'b0;

  function automatic int unsigned eff_dim(logic [3:0] raw);
    if (raw == 0) return 1;
    return (raw > DIM_MAX) ? DIM_MAX : raw;
  endfunction

  function automatic longint sat_q(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint abs_l(longint v);
    return (v < 0) ? -v : v;
  endfunction

  // q16.16 product, rounded half away from zero
  function automatic longint q_mul(longint a, longint b);
    longint p;
    longint m;
    p = a * b;
    m = (abs_l(p) + (64'sd1 << (FRAC - 1))) >>> FRAC;
    return sat_q((p < 0) ? -m : m);
  endfunction

  // q16.16 quotient, rounded half away from zero; divisor is never zero here
  function automatic longint q_div(longint a, longint b);
    longint num;
    longint den;
    longint q;
    num = abs_l(a) <<< FRAC;
    den = abs_l(b);
    q = (2 * num + den) / (2 * den);
    if (q > (64'sd1 <<< 40)) q = 64'sd1 <<< 40;
    return sat_q(((a < 0) != (b < 0)) ? -q : q);
  endfunction

  // forward elimination on the stored run, queueing every element in row-major order
  task automatic reduce_and_queue(int unsigned nr, int unsigned nc);
    longint mat[DIM_MAX][DIM_MAX];
    longint best;
    longint coeff;
    longint tmp;
    int unsigned h;
    int unsigned k;
    int unsigned piv;
    echelon_elem_t e;
    for (int unsigned i = 0; i < nr; i++)
      for (int unsigned j = 0; j < nc; j++)
        mat[i][j] = longint'($signed(elem_store[i*nc + j]));
    h = 0;
    k = 0;
    while (h < nr && k < nc) begin
      best = 0;
      piv = h;
      // first row with the largest magnitude wins ties
      for (int unsigned i = h; i < nr; i++)
        if (abs_l(mat[i][k]) > best) begin
          best = abs_l(mat[i][k]);
          piv = i;
        end
      if (best == 0) begin
        k++;
        continue;
      end
      if (piv != h)
        for (int unsigned j = 0; j < nc; j++) begin
          tmp = mat[h][j];
          mat[h][j] = mat[piv][j];
          mat[piv][j] = tmp;
        end
      for (int unsigned i = h + 1; i < nr; i++) begin
        coeff = q_div(mat[i][k], mat[h][k]);
        mat[i][k] = 0;
        for (int unsigned j = k + 1; j < nc; j++)
          mat[i][j] = sat_q(mat[i][j] - q_mul(mat[h][j], coeff));
      end
      h++;
      k++;
    end
    for (int unsigned i = 0; i < nr; i++)
      for (int unsigned j = 0; j < nc; j++) begin
        e.value = mat[i][j][31:0];
        e.row = i[2:0];
        e.col = j[2:0];
        e.last = (i == nr - 1) && (j == nc - 1);
        echelon_due.push_back(e);
      end
  endtask

  task automatic load_element(logic [31:0] v);
    int unsigned total;
    total = eff_dim(rows_reg) * eff_dim(cols_reg);
    if (elems_loaded < DIM_MAX * DIM_MAX) elem_store[elems_loaded] = v;
    elems_loaded++;
    if (elems_loaded >= total) begin
      elems_loaded = 0;
      reduce_and_queue(eff_dim(rows_reg), eff_dim(cols_reg));
    end
  endtask

  // driver: offers pending elements, predicts on every accepted transaction
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) load_element(s_tdata);
      if (!s_tvalid || s_tready) begin
        if (pending_elems.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          s_tvalid <= 1'b1;
          s_tdata <= pending_elems.pop_front();
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor and receiver: checks each result transaction, stalls at random, holds once
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;
  always @(posedge clk) begin
    echelon_elem_t exp_e;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        results_seen++;
        if (echelon_due.size() == 0) begin
          $error("result with nothing expected: tdata %h", m_tdata);
          failed = 1'b1;
        end else begin
          exp_e = echelon_due.pop_front();
          if (m_tdata[31:0] !== exp_e.value) begin
            $error("result_value expected %h actual %h", exp_e.value, m_tdata[31:0]);
            failed = 1'b1;
          end
          if (m_tdata[34:32] !== exp_e.row) begin
            $error("result_row expected %0d actual %0d", exp_e.row, m_tdata[34:32]);
            failed = 1'b1;
          end
          if (m_tdata[37:35] !== exp_e.col) begin
            $error("result_col expected %0d actual %0d", exp_e.col, m_tdata[37:35]);
            failed = 1'b1;
          end
          if (m_tlast !== exp_e.last) begin
            $error("last_of_run expected %0d actual %0d", exp_e.last, m_tlast);
            failed = 1'b1;
          end
        end
      end
      // long back-pressure once, while the sender is offering and blocked
      if (!hold_done && results_seen >= 40 && s_tvalid && !s_tready) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // watchdog on cycles without any transaction
  int unsigned quiet_cycles = 0;
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready) || rst)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [3:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    forever begin
      @(posedge clk);
      if (cfg_ready) break;
    end
    if (idx == CFG_ROWS_IN_USE) rows_reg = val;
    else if (idx == CFG_COLS_IN_USE) cols_reg = val;
    cfg_valid <= 1'b0;
  endtask

  // block until every element went in and every result came out
  task automatic drain();
    while (pending_elems.size() != 0 || s_tvalid || echelon_due.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_elem();
    int unsigned pick;
    logic [31:0] v;
    pick = $urandom_range(99);
    if (pick < 10) v = 32'h0;
    else if (pick < 15) v = 32'h8000_0000;
    else if (pick < 20) v = 32'h7fff_ffff;
    else if (pick < 60) begin
      v = $urandom_range(5 << FRAC);
      if ($urandom_range(1)) v = -v;
    end else v = $urandom;
    return v;
  endfunction

  task automatic set_size(logic [3:0] r, logic [3:0] c);
    write_reg(CFG_ROWS_IN_USE, r);
    write_reg(CFG_COLS_IN_USE, c);
  endtask

  task automatic push_rows(logic [31:0] vals[]);
    foreach (vals[i]) pending_elems.push_back(vals[i]);
    items_sent += vals.size();
  endtask

  initial begin
    int unsigned phase;
    int unsigned n;
    int unsigned mats;
    logic [3:0] r;
    logic [3:0] c;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // single element, most negative value
    set_size(4'd1, 4'd1);
    push_rows('{32'h8000_0000});
    drain();
    // zero leading column moves only the column
    set_size(4'd2, 4'd2);
    push_rows('{32'h0, 32'h0005_0000, 32'h0, 32'h0007_0000});
    drain();
    // equal magnitudes: first row found keeps the pivot; swap below
    write_reg(CFG_SPARE_A, 4'd5);
    write_reg(CFG_SPARE_B, 4'd9);
    set_size(4'd3, 4'd3);
    push_rows('{32'h0001_0000, 32'h0002_0000, 32'h0003_0000,
                32'hfffd_0000, 32'h0001_8000, 32'h7fff_ffff,
                32'h0003_0000, 32'h8000_0000, 32'h0000_0001});
    drain();
    // differences that saturate both ways
    set_size(4'd2, 4'd3);
    push_rows('{32'h0001_0000, 32'h8000_0000, 32'h7fff_ffff,
                32'hffff_0000, 32'h8000_0000, 32'h7fff_ffff});
    drain();

    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 83; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 83; end
        default: begin send_idle_pct = 21; recv_stall_pct = 21; end
      endcase
      // out-of-range sizes and the full 8x8 appear in a few phases only
      if (phase == 1) begin r = 4'd15; c = 4'd0; end
      else if (phase == 3) begin r = 4'd8; c = 4'd8; end
      else if (phase == 5) begin r = 4'd0; c = 4'd12; end
      else begin
        r = $urandom_range(1, 4);
        c = $urandom_range(1, 5);
      end
      set_size(r, c);
      n = eff_dim(r) * eff_dim(c);
      mats = (n >= 32) ? 1 : (30 / n) + 1;
      repeat (mats) begin
        for (int unsigned i = 0; i < n; i++) pending_elems.push_back(rand_elem());
        items_sent += n;
      end
      drain();
      phase++;
    end

    if (!failed) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
